// File: src/mqmb_pkg.sv
// Mailbox package: field widths, command and status codes, default sizes
// and the transaction types of the command and result channels.
// No dependencies.
`default_nettype none
package mqmb_pkg;

	localparam int CMD_W    = 3;
	localparam int QUEUE_W  = 3;
	localparam int TASK_W   = 4;
	localparam int WORD_W   = 32;
	localparam int MAXW_W   = 4;
	localparam int STATUS_W = 3;
	localparam int COUNT_W  = 4;

	localparam int RESULT_CAP = 8;

	localparam int DEF_NUM_QUEUES   = 8;
	localparam int DEF_QUEUE_DEPTH  = 8;
	localparam int DEF_MSG_WORDS    = 8;
	localparam int DEF_WAITER_SLOTS = 4;
	localparam int DEF_MAX_TASKS    = 15;

	localparam logic [CMD_W-1:0] CMD_CREATE  = 3'd0;
	localparam logic [CMD_W-1:0] CMD_SEND    = 3'd1;
	localparam logic [CMD_W-1:0] CMD_RECV    = 3'd2;
	localparam logic [CMD_W-1:0] CMD_DELETE  = 3'd3;
	localparam logic [CMD_W-1:0] CMD_RELEASE = 3'd4;

	localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
	localparam logic [STATUS_W-1:0] ST_BAD_ARG = 3'd1;
	localparam logic [STATUS_W-1:0] ST_FULL    = 3'd2;
	localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd3;
	localparam logic [STATUS_W-1:0] ST_WL_FULL = 3'd4;
	localparam logic [STATUS_W-1:0] ST_NO_FREE = 3'd5;
	localparam logic [STATUS_W-1:0] ST_BLOCK   = 3'd6;

	typedef struct packed {
		logic [CMD_W-1:0]   cmd;
		logic [QUEUE_W-1:0] queue;
		logic [TASK_W-1:0]  task_req;
		logic [WORD_W-1:0]  word;
		logic               last;
		logic [MAXW_W-1:0]  max_words;
		logic               wait_req;
	} req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [WORD_W-1:0]   data_word;
		logic [COUNT_W-1:0]  word_count;
		logic [QUEUE_W-1:0]  created_queue;
		logic [TASK_W-1:0]   woken_task;
		logic                run_end;
	} rsp_t;

endpackage
`default_nettype wire

// File: src/mqmb_if.sv
// Valid/ready channel interfaces for mailbox commands and results.
// Depends on mqmb_pkg.
`default_nettype none
interface mqmb_req_if import mqmb_pkg::*; ();
	logic valid;
	logic ready;
	req_t payload;
	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

interface mqmb_rsp_if import mqmb_pkg::*; ();
	logic valid;
	logic ready;
	rsp_t payload;
	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface
`default_nettype wire

// File: src/multi_queue_message_mailbox.sv
// Multi-queue message mailbox top level: sequencer, queue state, waiter lists.
// Depends on mqmb_pkg, mqmb_if and mqmb_ram.
//
// One command is taken at a time; req.ready is high only while the sequencer is idle,
// and a finished result may still wait in the output register when the next command
// is taken. Each command passes through a decode state, then its own sequence, then a
// flush state that hands over its last result: create scans one queue per cycle (up
// to NUM_QUEUES queues), a committing send writes one word per cycle into the message
// RAM, a receive reads the length then one word per cycle up to the words delivered,
// delete visits one waiter slot per cycle (2*WAITER_SLOTS slots), release visits one
// queue per cycle (NUM_QUEUES queues). Other commands go from decode straight to flush.
// Each step stalls while the output register is full; rates above assume no stall.
// Message words live in a single-port-per-side RAM; no clearing pass is needed.
`default_nettype none
module multi_queue_message_mailbox import mqmb_pkg::*; #(
	parameter int NUM_QUEUES   = DEF_NUM_QUEUES,
	parameter int QUEUE_DEPTH  = DEF_QUEUE_DEPTH,
	parameter int MSG_WORDS    = DEF_MSG_WORDS,
	parameter int WAITER_SLOTS = DEF_WAITER_SLOTS,
	parameter int MAX_TASKS    = DEF_MAX_TASKS
) (
	input  logic      clk,
	input  logic      arst_n,
	mqmb_req_if.sink  req,
	mqmb_rsp_if.source rsp
);
	localparam int QI_W = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
	localparam int SL_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int FL_W = $clog2(QUEUE_DEPTH + 1);
	localparam int MI_W = (MSG_WORDS > 1) ? $clog2(MSG_WORDS) : 1;
	localparam int LN_W = $clog2(MSG_WORDS + 1);
	localparam int WI_W = (WAITER_SLOTS > 1) ? $clog2(WAITER_SLOTS) : 1;
	localparam int JS_W = $clog2(2 * WAITER_SLOTS);
	localparam int ST_DEPTH = NUM_QUEUES * QUEUE_DEPTH * MSG_WORDS;
	localparam int LN_DEPTH = NUM_QUEUES * QUEUE_DEPTH;
	localparam int SA_W = (ST_DEPTH > 1) ? $clog2(ST_DEPTH) : 1;
	localparam int LA_W = (LN_DEPTH > 1) ? $clog2(LN_DEPTH) : 1;
	localparam int KC_W = $clog2(RESULT_CAP + 1);

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_EXEC   = 4'd1;
	localparam logic [3:0] S_CREATE = 4'd2;
	localparam logic [3:0] S_STORE  = 4'd3;
	localparam logic [3:0] S_RLEN   = 4'd4;
	localparam logic [3:0] S_RDATA  = 4'd5;
	localparam logic [3:0] S_DEL    = 4'd6;
	localparam logic [3:0] S_REL    = 4'd7;
	localparam logic [3:0] S_FLUSH  = 4'd8;

	typedef logic [WAITER_SLOTS-1:0][TASK_W-1:0] row_t;

	function automatic row_t wake_row(row_t r);
		row_t o;
		logic done;
		o = r;
		done = 1'b0;
		for (int j = 0; j < WAITER_SLOTS; j++) begin
			if (!done && r[j] != '0) begin
				o[j] = '0;
				done = 1'b1;
			end
		end
		return o;
	endfunction

	function automatic logic [TASK_W-1:0] wake_task(row_t r);
		logic [TASK_W-1:0] t;
		logic done;
		t = '0;
		done = 1'b0;
		for (int j = 0; j < WAITER_SLOTS; j++) begin
			if (!done && r[j] != '0) begin
				t = r[j];
				done = 1'b1;
			end
		end
		return t;
	endfunction

	function automatic logic row_has(row_t r, logic [TASK_W-1:0] t);
		logic h;
		h = 1'b0;
		for (int j = 0; j < WAITER_SLOTS; j++) begin
			if (r[j] == t) begin
				h = 1'b1;
			end
		end
		return h;
	endfunction

	function automatic row_t add_row(row_t r, logic [TASK_W-1:0] t);
		row_t o;
		logic done;
		o = r;
		done = row_has(r, t);
		for (int j = 0; j < WAITER_SLOTS; j++) begin
			if (!done && r[j] == '0) begin
				o[j] = t;
				done = 1'b1;
			end
		end
		return o;
	endfunction

	function automatic row_t drop_row(row_t r, logic [TASK_W-1:0] t);
		row_t o;
		o = r;
		for (int j = 0; j < WAITER_SLOTS; j++) begin
			if (r[j] == t) begin
				o[j] = '0;
			end
		end
		return o;
	endfunction

	function automatic logic [SA_W-1:0] store_addr(logic [QI_W-1:0] qx, logic [SL_W-1:0] sx);
		return SA_W'((32'(qx) * QUEUE_DEPTH + 32'(sx)) * MSG_WORDS);
	endfunction

	function automatic logic [LA_W-1:0] len_addr(logic [QI_W-1:0] qx, logic [SL_W-1:0] sx);
		return LA_W'(32'(qx) * QUEUE_DEPTH + 32'(sx));
	endfunction

	function automatic logic [SL_W-1:0] slot_inc(logic [SL_W-1:0] s);
		return (32'(s) == QUEUE_DEPTH - 1) ? '0 : s + SL_W'(1);
	endfunction

	logic [3:0]                    state_q;
	req_t                          it_q;
	logic [NUM_QUEUES-1:0]         in_use_q;
	logic [NUM_QUEUES-1:0][TASK_W-1:0] creator_q;
	logic [NUM_QUEUES-1:0][SL_W-1:0]   rd_q;
	logic [NUM_QUEUES-1:0][SL_W-1:0]   wr_q;
	logic [NUM_QUEUES-1:0][FL_W-1:0]   fill_q;
	row_t [NUM_QUEUES-1:0]         swl_q;
	row_t [NUM_QUEUES-1:0]         rwl_q;
	logic [WORD_W-1:0]             stage_q [MSG_WORDS];
	logic [LN_W-1:0]               scount_q;
	logic                          ovf_q;
	logic [QI_W-1:0]               qscan_q;
	logic [JS_W-1:0]               jscan_q;
	logic [MI_W-1:0]               widx_q;
	logic [LN_W-1:0]               len_q;
	logic [COUNT_W-1:0]            n_q;
	logic [TASK_W-1:0]             woken_q;
	logic [SA_W-1:0]               base_q;
	logic [KC_W-1:0]               k_q;
	rsp_t                          pend_q;
	logic                          pend_v_q;
	rsp_t                          out_q;
	logic                          out_v_q;

	logic              adv;
	logic              qv;
	logic [QI_W-1:0]   qi;
	logic              qok;
	row_t              srow;
	row_t              rrow;
	logic              ovf_now;
	logic              full;
	logic              empty;
	logic              blk;
	logic              add_fail;
	logic              recv_bad;
	logic              recv_go;
	logic              rel_skip;
	logic [TASK_W-1:0] del_t;
	logic              del_end;
	logic              emit_en;
	rsp_t              emit_r;
	logic              emit_ok;
	logic              out_ld;
	rsp_t              out_d;
	logic              st_we;
	logic [SA_W-1:0]   st_waddr;
	logic              st_re;
	logic [SA_W-1:0]   st_raddr;
	logic [WORD_W-1:0] st_rdata;
	logic              ln_we;
	logic [LA_W-1:0]   ln_waddr;
	logic              ln_re;
	logic [LA_W-1:0]   ln_raddr;
	logic [LN_W-1:0]   ln_rdata;
	logic [31:0]       n_min;

	assign adv      = !out_v_q || rsp.ready;
	assign qv       = 32'(it_q.queue) < NUM_QUEUES;
	assign qi       = QI_W'(32'(it_q.queue));
	assign qok      = qv && in_use_q[qi];
	assign srow     = swl_q[qi];
	assign rrow     = rwl_q[qi];
	assign ovf_now  = ovf_q || (32'(scount_q) == MSG_WORDS);
	assign full     = 32'(fill_q[qi]) == QUEUE_DEPTH;
	assign empty    = fill_q[qi] == '0;
	assign blk      = it_q.wait_req && (it_q.task_req != '0);
	assign add_fail = (it_q.cmd == CMD_SEND)
		? (!row_has(srow, it_q.task_req) && !row_has(srow, '0))
		: (!row_has(rrow, it_q.task_req) && !row_has(rrow, '0));
	assign recv_bad = (it_q.max_words == '0) || (32'(it_q.max_words) > MSG_WORDS) || !qok;
	assign recv_go  = (it_q.cmd == CMD_RECV) && !recv_bad && !empty;
	assign rel_skip = (it_q.task_req == '0) || (32'(it_q.task_req) > MAX_TASKS);
	assign del_t    = (32'(jscan_q) < WAITER_SLOTS)
		? srow[WI_W'(32'(jscan_q))]
		: rrow[WI_W'(32'(jscan_q) - WAITER_SLOTS)];
	assign del_end  = 32'(jscan_q) == 2 * WAITER_SLOTS - 1;
	assign n_min    = (32'(ln_rdata) > 32'(it_q.max_words)) ? 32'(it_q.max_words)
		: 32'(ln_rdata);

	always_comb begin
		emit_en = 1'b0;
		emit_r  = '0;
		unique case (state_q)
			S_EXEC: begin
				emit_en = 1'b1;
				case (it_q.cmd)
					CMD_CREATE: emit_en = 1'b0;
					CMD_SEND: begin
						if (!it_q.last) begin
							emit_r.status = ST_OK;
						end else if (ovf_now || !qok) begin
							emit_r.status = ST_BAD_ARG;
						end else if (!full) begin
							emit_en = 1'b0;
						end else if (!blk) begin
							emit_r.status = ST_FULL;
						end else begin
							emit_r.status = add_fail ? ST_WL_FULL : ST_BLOCK;
						end
					end
					CMD_RECV: begin
						if (recv_bad) begin
							emit_r.status = ST_BAD_ARG;
						end else if (!empty) begin
							emit_en = 1'b0;
						end else if (!blk) begin
							emit_r.status = ST_EMPTY;
						end else begin
							emit_r.status = add_fail ? ST_WL_FULL : ST_BLOCK;
						end
					end
					CMD_DELETE: begin
						emit_en = !qv;
						emit_r.status = ST_BAD_ARG;
					end
					CMD_RELEASE: begin
						emit_en = rel_skip;
						emit_r.status = ST_OK;
					end
					default: emit_r.status = ST_BAD_ARG;
				endcase
			end
			S_CREATE: begin
				if (!in_use_q[qscan_q]) begin
					emit_en = 1'b1;
					emit_r.created_queue = QUEUE_W'(32'(qscan_q));
				end else if (32'(qscan_q) == NUM_QUEUES - 1) begin
					emit_en = 1'b1;
					emit_r.status = ST_NO_FREE;
				end
			end
			S_STORE: begin
				emit_en = 32'(widx_q) == 32'(len_q) - 1;
				emit_r.woken_task = wake_task(rrow);
			end
			S_RDATA: begin
				emit_en = 1'b1;
				emit_r.data_word  = st_rdata;
				emit_r.word_count = n_q;
				emit_r.woken_task = woken_q;
			end
			S_DEL: begin
				emit_en = (del_t != '0) || (del_end && !pend_v_q);
				emit_r.woken_task = del_t;
			end
			S_REL: emit_en = 32'(qscan_q) == NUM_QUEUES - 1;
			default: emit_en = 1'b0;
		endcase
	end

	always_comb begin
		out_d         = pend_q;
		out_d.run_end = state_q == S_FLUSH;
	end

	assign emit_ok  = adv && emit_en && (32'(k_q) < RESULT_CAP);
	assign out_ld   = adv && ((emit_ok && pend_v_q) || (state_q == S_FLUSH));

	assign st_we    = adv && (state_q == S_STORE);
	assign st_waddr = base_q + SA_W'(widx_q);
	assign st_re    = adv && ((state_q == S_RLEN) || (state_q == S_RDATA));
	assign st_raddr = (state_q == S_RLEN) ? base_q : base_q + SA_W'(32'(widx_q) + 1);
	assign ln_we    = st_we && (32'(widx_q) == 32'(len_q) - 1);
	assign ln_waddr = len_addr(qi, wr_q[qi]);
	assign ln_re    = adv && (state_q == S_EXEC) && recv_go;
	assign ln_raddr = len_addr(qi, rd_q[qi]);

	mqmb_ram #(.WIDTH(WORD_W), .DEPTH(ST_DEPTH)) u_store (
		.clk(clk), .we(st_we), .waddr(st_waddr), .wdata(stage_q[widx_q]),
		.re(st_re), .raddr(st_raddr), .rdata(st_rdata)
	);

	mqmb_ram #(.WIDTH(LN_W), .DEPTH(LN_DEPTH)) u_len (
		.clk(clk), .we(ln_we), .waddr(ln_waddr), .wdata(len_q),
		.re(ln_re), .raddr(ln_raddr), .rdata(ln_rdata)
	);

	assign req.ready   = state_q == S_IDLE;
	assign rsp.valid   = out_v_q;
	assign rsp.payload = out_q;

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && req.valid) begin
			it_q <= req.payload;
		end
		if (adv && state_q == S_EXEC && it_q.cmd == CMD_SEND
			&& 32'(scount_q) < MSG_WORDS) begin
			stage_q[scount_q[MI_W-1:0]] <= it_q.word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			in_use_q  <= '0;
			creator_q <= '0;
			rd_q      <= '0;
			wr_q      <= '0;
			fill_q    <= '0;
			swl_q     <= '0;
			rwl_q     <= '0;
			scount_q  <= '0;
			ovf_q     <= 1'b0;
			qscan_q   <= '0;
			jscan_q   <= '0;
			widx_q    <= '0;
			len_q     <= '0;
			n_q       <= '0;
			woken_q   <= '0;
			base_q    <= '0;
			k_q       <= '0;
			pend_q    <= '0;
			pend_v_q  <= 1'b0;
			out_q     <= '0;
			out_v_q   <= 1'b0;
		end else begin
			if (out_ld) begin
				out_q   <= out_d;
				out_v_q <= 1'b1;
			end else if (rsp.ready) begin
				out_v_q <= 1'b0;
			end
			if (emit_ok) begin
				pend_q   <= emit_r;
				pend_v_q <= 1'b1;
				k_q      <= k_q + KC_W'(1);
			end
			unique case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						k_q     <= '0;
						qscan_q <= '0;
						jscan_q <= '0;
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (adv) begin
						case (it_q.cmd)
							CMD_CREATE: state_q <= S_CREATE;
							CMD_SEND: begin
								if (it_q.last) begin
									scount_q <= '0;
									ovf_q    <= 1'b0;
									len_q    <= scount_q + LN_W'(1);
									if (!ovf_now && qok && !full) begin
										base_q  <= store_addr(qi, wr_q[qi]);
										widx_q  <= '0;
										state_q <= S_STORE;
									end else begin
										state_q <= S_FLUSH;
										if (!ovf_now && qok) begin
											if (!blk) begin
												if (it_q.task_req != '0) begin
													swl_q[qi] <= drop_row(srow, it_q.task_req);
												end
											end else begin
												swl_q[qi] <= add_row(srow, it_q.task_req);
											end
										end
									end
								end else begin
									state_q <= S_FLUSH;
									if (32'(scount_q) < MSG_WORDS) begin
										scount_q <= scount_q + LN_W'(1);
									end else begin
										ovf_q <= 1'b1;
									end
								end
							end
							CMD_RECV: begin
								if (recv_go) begin
									base_q    <= store_addr(qi, rd_q[qi]);
									rd_q[qi]  <= slot_inc(rd_q[qi]);
									fill_q[qi] <= fill_q[qi] - FL_W'(1);
									swl_q[qi] <= wake_row(srow);
									woken_q   <= wake_task(srow);
									state_q   <= S_RLEN;
								end else begin
									state_q <= S_FLUSH;
									if (!recv_bad) begin
										if (!blk) begin
											if (it_q.task_req != '0) begin
												rwl_q[qi] <= drop_row(rrow, it_q.task_req);
											end
										end else begin
											rwl_q[qi] <= add_row(rrow, it_q.task_req);
										end
									end
								end
							end
							CMD_DELETE: state_q <= qv ? S_DEL : S_FLUSH;
							CMD_RELEASE: state_q <= rel_skip ? S_FLUSH : S_REL;
							default: state_q <= S_FLUSH;
						endcase
					end
				end
				S_CREATE: begin
					if (adv) begin
						if (!in_use_q[qscan_q]) begin
							in_use_q[qscan_q]  <= 1'b1;
							creator_q[qscan_q] <= it_q.task_req;
							rd_q[qscan_q]      <= '0;
							wr_q[qscan_q]      <= '0;
							fill_q[qscan_q]    <= '0;
							state_q            <= S_FLUSH;
						end else if (32'(qscan_q) == NUM_QUEUES - 1) begin
							state_q <= S_FLUSH;
						end else begin
							qscan_q <= qscan_q + QI_W'(1);
						end
					end
				end
				S_STORE: begin
					if (adv) begin
						if (32'(widx_q) == 32'(len_q) - 1) begin
							wr_q[qi]   <= slot_inc(wr_q[qi]);
							fill_q[qi] <= fill_q[qi] + FL_W'(1);
							rwl_q[qi]  <= wake_row(rrow);
							state_q    <= S_FLUSH;
						end else begin
							widx_q <= widx_q + MI_W'(1);
						end
					end
				end
				S_RLEN: begin
					if (adv) begin
						n_q     <= COUNT_W'(n_min);
						widx_q  <= '0;
						state_q <= S_RDATA;
					end
				end
				S_RDATA: begin
					if (adv) begin
						if (32'(widx_q) == 32'(n_q) - 1) begin
							state_q <= S_FLUSH;
						end else begin
							widx_q <= widx_q + MI_W'(1);
						end
					end
				end
				S_DEL: begin
					if (adv) begin
						if (del_end) begin
							swl_q[qi]     <= '0;
							rwl_q[qi]     <= '0;
							in_use_q[qi]  <= 1'b0;
							creator_q[qi] <= '0;
							rd_q[qi]      <= '0;
							wr_q[qi]      <= '0;
							fill_q[qi]    <= '0;
							state_q       <= S_FLUSH;
						end else begin
							jscan_q <= jscan_q + JS_W'(1);
						end
					end
				end
				S_REL: begin
					if (adv) begin
						if (in_use_q[qscan_q]) begin
							if (creator_q[qscan_q] == it_q.task_req) begin
								swl_q[qscan_q]     <= '0;
								rwl_q[qscan_q]     <= '0;
								in_use_q[qscan_q]  <= 1'b0;
								creator_q[qscan_q] <= '0;
								rd_q[qscan_q]      <= '0;
								wr_q[qscan_q]      <= '0;
								fill_q[qscan_q]    <= '0;
							end else begin
								swl_q[qscan_q] <= drop_row(swl_q[qscan_q], it_q.task_req);
								rwl_q[qscan_q] <= drop_row(rwl_q[qscan_q], it_q.task_req);
							end
						end
						if (32'(qscan_q) == NUM_QUEUES - 1) begin
							state_q <= S_FLUSH;
						end else begin
							qscan_q <= qscan_q + QI_W'(1);
						end
					end
				end
				S_FLUSH: begin
					if (adv) begin
						pend_v_q <= 1'b0;
						state_q  <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// File: src/mqmb_ram.sv
// Generic simple dual-port RAM with registered read.
// Depends on mqmb_pkg for default sizes.
`default_nettype none
module mqmb_ram import mqmb_pkg::*; #(
	parameter int WIDTH = WORD_W,
	parameter int DEPTH = DEF_NUM_QUEUES * DEF_QUEUE_DEPTH * DEF_MSG_WORDS,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule
`default_nettype wire

// File: src/mqmb_checker.sv
// Port-level checker for the mailbox, bound to the top level.
// Depends on mqmb_pkg and multi_queue_message_mailbox.
`default_nettype none
module mqmb_checker import mqmb_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input logic rsp_valid,
	input logic rsp_ready,
	input rsp_t rsp_payload
);
	logic [1:0] open_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= '0;
		end else begin
			open_q <= open_q + 2'(req_valid && req_ready)
				- 2'(rsp_valid && rsp_ready && rsp_payload.run_end);
		end
	end

	a_one_open: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |-> open_q < 2'd2)
		else $error("command taken while two are open");

	a_no_orphan: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> open_q != 2'd0)
		else $error("result with no open command");

	a_busy_after: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("ready held after a command transaction");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
		else $error("stalled result changed");
endmodule

bind multi_queue_message_mailbox mqmb_checker u_mqmb_checker (
	.clk(clk),
	.arst_n(arst_n),
	.req_valid(req.valid),
	.req_ready(req.ready),
	.rsp_valid(rsp.valid),
	.rsp_ready(rsp.ready),
	.rsp_payload(rsp.payload)
);
`default_nettype wire
